FILE: sv/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants for the graph reachability counter
// Widths of the stores and the command and state codes.
// ----------------------------------------------------------------------------
package grc_pkg;
  localparam int NODE_W = 14;
  localparam int MAX_NODES = 16384;
  localparam int MAX_EDGES = 16384;
  localparam int EIDX_W = 14;
  localparam int LINK_W = 15;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_SEED = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADD,
    ST_SEED,
    ST_POP,
    ST_POPW,
    ST_HEAD,
    ST_EDGE,
    ST_EDGEW,
    ST_CHECK,
    ST_SCAN,
    ST_SCANW,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;     // clear list_head and marked at clr_addr
    logic clr_start;
    logic do_add;       // write the latched edge into the store
    logic in_take;      // latch the beat, read marked and list head at its node
    logic seed_push;    // mark and push the seed
    logic pop_rd;       // pop stack into the node register
    logic head_ld;      // take list head into edge pointer
    logic edge_rd;      // read edge at pointer
    logic dest_rd;      // read marked at edge destination
    logic dest_push;    // mark and push destination, advance pointer
    logic adv;          // advance pointer only
    logic scan_start;
    logic scan_rd;
    logic scan_acc;
    logic out_ld;
  } grc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic seed_ok;      // seed unmarked
    logic stack_empty;
    logic ptr_null;
    logic dest_ok;      // destination unmarked, stack not full
    logic scan_done;
  } grc_stat_t;
endpackage

FILE: sv/grc_if.sv
// ----------------------------------------------------------------------------
// grc_in_if / grc_out_if: valid-ready channels of the block
// One beat carries one item.
// ----------------------------------------------------------------------------
interface grc_in_if;
  import grc_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] target;
  logic [NODE_W-1:0] node_count;
  modport source(output valid, command, node, target, node_count, input ready);
  modport sink(input valid, command, node, target, node_count, output ready);
endinterface

interface grc_out_if;
  import grc_pkg::*;
  logic valid;
  logic ready;
  logic [NODE_W-1:0] reached_count;
  logic edge_overflow;
  modport source(output valid, reached_count, edge_overflow, input ready);
  modport sink(input valid, reached_count, edge_overflow, output ready);
endinterface

FILE: sv/grc_datapath.sv
// ----------------------------------------------------------------------------
// grc_datapath: graph stores, walk stack and counters
// Holds the edge, head, mark and stack memories and the walk registers.
// ----------------------------------------------------------------------------
module grc_datapath
  import grc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  grc_cmd_t cmd,
  output grc_stat_t stat,
  input  logic [NODE_W-1:0] in_node,
  input  logic [NODE_W-1:0] in_target,
  input  logic [NODE_W-1:0] in_count,
  output logic [NODE_W-1:0] reached_count,
  output logic edge_overflow
);
  logic [NODE_W-1:0] edge_dest [MAX_EDGES];
  logic [LINK_W-1:0] edge_link [MAX_EDGES];
  logic [LINK_W-1:0] list_head [MAX_NODES];
  logic              marked    [MAX_NODES];
  logic [NODE_W-1:0] walk_stack [MAX_NODES];

  logic [NODE_W:0] clr_addr;
  logic [LINK_W-1:0] edges_used;
  logic dropped_flag;
  logic [NODE_W:0] top;
  logic [LINK_W-1:0] ptr;
  logic [NODE_W-1:0] node_q;
  logic [NODE_W-1:0] target_q;
  logic [NODE_W-1:0] stack_q;
  logic [LINK_W-1:0] head_q;
  logic [NODE_W-1:0] edest_q;
  logic [LINK_W-1:0] elink_q;
  logic mark_q;
  logic [NODE_W:0] scan_i;
  logic [NODE_W:0] scan_end;
  logic [NODE_W-1:0] count;
  logic [NODE_W-1:0] mark_addr;
  logic mark_we;
  logic [NODE_W-1:0] mark_wa;
  logic mark_wd;
  logic head_we;
  logic [NODE_W-1:0] head_wa;
  logic [LINK_W-1:0] head_wd;
  logic add_ok;

  assign add_ok = (edges_used < LINK_W'(MAX_EDGES));

  always_comb begin
    mark_addr = in_node;
    if (cmd.dest_rd) mark_addr = edest_q;
    else if (cmd.scan_rd) mark_addr = scan_i[NODE_W-1:0];
    mark_we = 1'b0;
    mark_wa = node_q;
    mark_wd = 1'b1;
    if (cmd.clr_step) begin
      mark_we = 1'b1;
      mark_wa = clr_addr[NODE_W-1:0];
      mark_wd = 1'b0;
    end else if (cmd.seed_push) begin
      mark_we = 1'b1;
    end else if (cmd.dest_push) begin
      mark_we = 1'b1;
      mark_wa = edest_q;
    end
    head_we = cmd.clr_step || (cmd.do_add && add_ok);
    head_wa = cmd.clr_step ? clr_addr[NODE_W-1:0] : node_q;
    head_wd = cmd.clr_step ? '0 : edges_used + LINK_W'(1);
  end

  // The accepted beat is held here, since the channel may move on to the next one.
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      node_q <= in_node;
      target_q <= in_target;
    end
  end

  // Heads are read at the accepted node for an edge load and at the popped node in a walk.
  always_ff @(posedge clk) begin
    if (cmd.in_take) head_q <= list_head[in_node];
    if (head_we) list_head[head_wa] <= head_wd;
    if (cmd.head_ld) ptr <= list_head[stack_q];
    else if (cmd.dest_push || cmd.adv) ptr <= elink_q;
  end

  always_ff @(posedge clk) begin
    if (mark_we) marked[mark_wa] <= mark_wd;
    mark_q <= marked[mark_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.do_add && add_ok) begin
      edge_dest[edges_used[EIDX_W-1:0]] <= target_q;
      edge_link[edges_used[EIDX_W-1:0]] <= head_q;
    end
    if (cmd.edge_rd) begin
      edest_q <= edge_dest[ptr[EIDX_W-1:0] - EIDX_W'(1)];
      elink_q <= edge_link[ptr[EIDX_W-1:0] - EIDX_W'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_rd) stack_q <= walk_stack[top[NODE_W-1:0] - NODE_W'(1)];
    if (cmd.seed_push) walk_stack[top[NODE_W-1:0]] <= node_q;
    else if (cmd.dest_push) walk_stack[top[NODE_W-1:0]] <= edest_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      edges_used <= '0;
      dropped_flag <= 1'b0;
      top <= '0;
      count <= '0;
      scan_i <= '0;
    end else begin
      if (cmd.clr_start) clr_addr <= '0;
      else if (cmd.clr_step) clr_addr <= clr_addr + (NODE_W+1)'(1);
      if (cmd.clr_start) begin
        edges_used <= '0;
        dropped_flag <= 1'b0;
      end else if (cmd.do_add) begin
        if (add_ok) edges_used <= edges_used + LINK_W'(1);
        else dropped_flag <= 1'b1;
      end
      if (cmd.seed_push || cmd.dest_push) top <= top + (NODE_W+1)'(1);
      else if (cmd.pop_rd) top <= top - (NODE_W+1)'(1);
      if (cmd.scan_start) begin
        scan_i <= (NODE_W+1)'(1);
        count <= '0;
      end else if (cmd.scan_acc) begin
        scan_i <= scan_i + (NODE_W+1)'(1);
        if (mark_q) count <= count + NODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) scan_end <= {1'b0, in_count};
    if (cmd.out_ld) begin
      reached_count <= count;
      edge_overflow <= dropped_flag;
    end
  end

  assign stat.clr_done = (clr_addr == (NODE_W+1)'(MAX_NODES - 1));
  assign stat.seed_ok = !mark_q;
  assign stat.stack_empty = (top == '0);
  assign stat.ptr_null = (ptr == '0) || (ptr > LINK_W'(MAX_EDGES));
  assign stat.dest_ok = !mark_q && (top < (NODE_W+1)'(MAX_NODES));
  assign stat.scan_done = (scan_i > scan_end) || (scan_i >= (NODE_W+1)'(MAX_NODES));

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    top <= (NODE_W+1)'(MAX_NODES)) else $error("stack depth beyond node store");
  a_edges_bound: assert property (@(posedge clk) disable iff (rst)
    edges_used <= LINK_W'(MAX_EDGES)) else $error("edge count beyond store");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    $rose(dropped_flag) |-> edges_used == LINK_W'(MAX_EDGES))
    else $error("edge dropped while store not full");
endmodule

FILE: sv/grc_ctrl.sv
// ----------------------------------------------------------------------------
// grc_ctrl: controller of the graph reachability counter
// Sequences clearing, edge loads, walks and the report scan.
// ----------------------------------------------------------------------------
module grc_ctrl
  import grc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_command,
  output logic out_valid,
  input  logic out_ready,
  output grc_cmd_t cmd,
  input  grc_stat_t stat
);
  state_t state, state_next;
  cmd_t c;

  assign c = cmd_t'(in_command);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = (state == ST_INIT) ? ST_IDLE : ST_OUT;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_take = 1'b1;
          unique case (c)
            CMD_ADD: state_next = ST_ADD;
            CMD_SEED: state_next = ST_SEED;
            CMD_REPORT: begin
              cmd.scan_start = 1'b1;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_ADD: begin
        cmd.do_add = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SEED: begin
        if (stat.seed_ok) begin
          cmd.seed_push = 1'b1;
          state_next = ST_POP;
        end else state_next = ST_IDLE;
      end
      ST_POP: begin
        if (stat.stack_empty) state_next = ST_IDLE;
        else begin
          cmd.pop_rd = 1'b1;
          state_next = ST_POPW;
        end
      end
      ST_POPW: begin
        cmd.head_ld = 1'b1;
        state_next = ST_HEAD;
      end
      ST_HEAD, ST_EDGE: begin
        if (stat.ptr_null) state_next = ST_POP;
        else begin
          cmd.edge_rd = 1'b1;
          state_next = ST_EDGEW;
        end
      end
      ST_EDGEW: begin
        cmd.dest_rd = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.dest_ok) cmd.dest_push = 1'b1;
        else cmd.adv = 1'b1;
        state_next = ST_EDGE;
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          cmd.clr_start = 1'b1;
          cmd.out_ld = 1'b1;
          state_next = ST_CLEAR;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next = ST_SCANW;
        end
      end
      ST_SCANW: begin
        cmd.scan_acc = 1'b1;
        state_next = ST_SCAN;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_out_after_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_CLEAR) else $error("result before clear");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
endmodule

FILE: sv/graph_reachability_counter_core.sv
// Edge load: the edge is written after its beat is taken. Seed walk: an unmarked seed
// is marked and pushed; each popped node's edges are read and unmarked destinations are
// marked and pushed, until the stack is empty. Report: marks of nodes 1 to node_count
// are counted, then a clearing pass of heads and marks runs, then the result beat.
// Throughput: one item at a time; the next beat is taken once the previous item is done.
// Reset: synchronous; a clearing pass runs before the first beat is taken.
// ----------------------------------------------------------------------------
// graph_reachability_counter_core: graph reachability counter top level
// Stores a directed graph, walks it from seeds and reports reached nodes.
// ----------------------------------------------------------------------------
module graph_reachability_counter_core
  import grc_pkg::*;
(
  input logic clk,
  input logic rst,
  grc_in_if.sink in_ch,
  grc_out_if.source out_ch
);
  grc_cmd_t cmd;
  grc_stat_t stat;

  grc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.command),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  grc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_node(in_ch.node), .in_target(in_ch.target), .in_count(in_ch.node_count),
    .reached_count(out_ch.reached_count), .edge_overflow(out_ch.edge_overflow)
  );
endmodule
